// ===== sv/linear_adsr_envelope_defines.svh =====
// ----------------------------------------------------------------------------
// Linear ADSR envelope - assertion macros
// Concurrent assertion wrappers for the envelope top level.
// ----------------------------------------------------------------------------
`ifndef LINEAR_ADSR_ENVELOPE_DEFINES_SVH
`define LINEAR_ADSR_ENVELOPE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LAE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("envelope check failed");

// next-cycle implication, disabled while in reset
`define LAE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("envelope check failed");

`endif

// ===== sv/lae_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear ADSR envelope - package
// Command, phase and register index codes shared by the envelope modules.
// ----------------------------------------------------------------------------
package lae_pkg;

   // command carried by each request beat
   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_NOTE_ON  = 2'd1,
      CMD_NOTE_OFF = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   // envelope phase
   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_ATTACK  = 3'd1,
      PH_DECAY   = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4
   } phase_type;

   // control register indexes
   typedef enum logic [2:0] {
      REG_ATTACK_STEP       = 3'd0,
      REG_DECAY_STEP        = 3'd1,
      REG_RELEASE_STEP      = 3'd2,
      REG_RELEASE_TIME_STEP = 3'd3,
      REG_SUSTAIN_LEVEL     = 3'd4,
      REG_START_LEVEL       = 3'd5,
      REG_DECAY_DISABLED    = 3'd6,
      REG_BYPASS            = 3'd7
   } reg_index_type;

   localparam int unsigned REG_INDEX_BITS = 3;

   // single-bit mode flags
   typedef struct packed {
      logic decay_disabled;
      logic bypass;
   } ctrl_flags_type;

endpackage

// ===== sv/lae_csr.sv =====
// ----------------------------------------------------------------------------
// Linear ADSR envelope - control registers
// Write-only register file holding the step sizes, levels and mode flags.
// ----------------------------------------------------------------------------
module lae_csr #(
   parameter int LEVEL_FRAC_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [lae_pkg::REG_INDEX_BITS-1:0]   csr_index,
   input  logic [LEVEL_FRAC_BITS:0]             csr_write_data,
   output logic [LEVEL_FRAC_BITS:0]             attack_step,
   output logic [LEVEL_FRAC_BITS:0]             decay_step,
   output logic [LEVEL_FRAC_BITS:0]             release_step,
   output logic [LEVEL_FRAC_BITS:0]             release_time_step,
   output logic [LEVEL_FRAC_BITS:0]             sustain_level,
   output logic [LEVEL_FRAC_BITS:0]             start_level,
   output lae_pkg::ctrl_flags_type              flags
);
   import lae_pkg::*;

   localparam int LW = LEVEL_FRAC_BITS + 1;
   // default step is one 48th of full scale
   localparam longint unsigned DEF_STEP_VAL = (64'd1 << LEVEL_FRAC_BITS) / 48;
   localparam logic [LW-1:0] DEF_STEP = LW'(DEF_STEP_VAL);

   logic [LW-1:0]  attack_step_ff;
   logic [LW-1:0]  decay_step_ff;
   logic [LW-1:0]  release_step_ff;
   logic [LW-1:0]  release_time_step_ff;
   logic [LW-1:0]  sustain_level_ff;
   logic [LW-1:0]  start_level_ff;
   ctrl_flags_type flags_ff;
   reg_index_type  index;

   assign index = reg_index_type'(csr_index);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_step_ff       <= DEF_STEP;
         decay_step_ff        <= DEF_STEP;
         release_step_ff      <= '0;
         release_time_step_ff <= DEF_STEP;
         sustain_level_ff     <= '0;
         start_level_ff       <= '0;
         flags_ff             <= '0;
      end else if (csr_write_enable) begin
         unique case (index)
            REG_ATTACK_STEP:       attack_step_ff       <= csr_write_data;
            REG_DECAY_STEP:        decay_step_ff        <= csr_write_data;
            REG_RELEASE_STEP:      release_step_ff      <= csr_write_data;
            REG_RELEASE_TIME_STEP: release_time_step_ff <= csr_write_data;
            REG_SUSTAIN_LEVEL:     sustain_level_ff     <= csr_write_data;
            REG_START_LEVEL:       start_level_ff       <= csr_write_data;
            REG_DECAY_DISABLED:    flags_ff.decay_disabled <= csr_write_data[0];
            REG_BYPASS:            flags_ff.bypass         <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign attack_step       = attack_step_ff;
   assign decay_step        = decay_step_ff;
   assign release_step      = release_step_ff;
   assign release_time_step = release_time_step_ff;
   assign sustain_level     = sustain_level_ff;
   assign start_level       = start_level_ff;
   assign flags             = flags_ff;

endmodule

// ===== sv/lae_step.sv =====
// ----------------------------------------------------------------------------
// Linear ADSR envelope - step logic
// Combinational next level, next phase and next release progress for one beat.
// ----------------------------------------------------------------------------
module lae_step #(
   parameter int LEVEL_FRAC_BITS = 24
) (
   input  logic [1:0]                  cmd,
   input  logic [LEVEL_FRAC_BITS:0]    cur_level,
   input  lae_pkg::phase_type          phase,
   input  logic [LEVEL_FRAC_BITS:0]    progress,
   input  logic [LEVEL_FRAC_BITS:0]    attack_step,
   input  logic [LEVEL_FRAC_BITS:0]    decay_step,
   input  logic [LEVEL_FRAC_BITS:0]    release_step,
   input  logic [LEVEL_FRAC_BITS:0]    release_time_step,
   input  logic [LEVEL_FRAC_BITS:0]    sustain_level,
   input  logic [LEVEL_FRAC_BITS:0]    start_level,
   input  lae_pkg::ctrl_flags_type     flags,
   output logic [LEVEL_FRAC_BITS:0]    next_level,
   output lae_pkg::phase_type          next_phase,
   output logic [LEVEL_FRAC_BITS:0]    next_progress
);
   import lae_pkg::*;

   localparam int LW = LEVEL_FRAC_BITS + 1;
   localparam logic [LW-1:0] ONE_LVL = LW'(1) << LEVEL_FRAC_BITS;
   // 0.001 rounded to the nearest level step
   localparam longint unsigned EPS_VAL = ((64'd1 << LEVEL_FRAC_BITS) + 500) / 1000;
   localparam logic [LW-1:0] EPS_LVL = LW'(EPS_VAL);

   logic [LW:0]          att_sum;
   logic [LW:0]          prog_sum;
   logic signed [LW+1:0] dec_diff;
   logic signed [LW+1:0] dec_limit;
   logic signed [LW+1:0] rel_diff;
   cmd_type              cmd_code;

   assign cmd_code = cmd_type'(cmd);

   // datapath: the adds and subtracts for the attack, decay and release steps
   assign att_sum   = {1'b0, cur_level} + {1'b0, attack_step};
   assign prog_sum  = {1'b0, progress} + {1'b0, release_time_step};
   assign dec_diff  = $signed({2'b00, cur_level}) - $signed({2'b00, decay_step});
   assign dec_limit = $signed({2'b00, sustain_level} + {2'b00, EPS_LVL});
   assign rel_diff  = $signed({2'b00, cur_level}) - $signed({2'b00, release_step});

   always_comb begin
      next_level    = cur_level;
      next_phase    = phase;
      next_progress = progress;
      if (flags.bypass) begin
         next_level = ONE_LVL;
      end else begin
         unique case (cmd_code)
            CMD_TICK: begin
               unique case (phase)
                  PH_ATTACK: begin
                     if (att_sum >= {1'b0, ONE_LVL}) begin
                        next_level = ONE_LVL;
                        next_phase = PH_DECAY;
                     end else begin
                        next_level = att_sum[LW-1:0];
                     end
                  end
                  PH_DECAY: begin
                     next_phase = PH_SUSTAIN;
                     if (flags.decay_disabled) begin
                        next_level = ONE_LVL;
                     end else if (cur_level > sustain_level && dec_diff > dec_limit) begin
                        next_level = dec_diff[LW-1:0];
                        next_phase = PH_DECAY;
                     end else begin
                        next_level = sustain_level;
                     end
                  end
                  PH_RELEASE: begin
                     if (prog_sum >= {1'b0, ONE_LVL}) begin
                        // release time used up
                        next_progress = '0;
                        next_level    = '0;
                        next_phase    = PH_IDLE;
                     end else begin
                        next_progress = prog_sum[LW-1:0];
                        if (rel_diff <= $signed({2'b00, EPS_LVL})) begin
                           next_level = '0;
                           next_phase = PH_IDLE;
                        end else begin
                           next_level = rel_diff[LW-1:0];
                        end
                     end
                  end
                  default: ;  // idle and sustain echo the level
               endcase
            end
            CMD_NOTE_ON: begin
               next_phase = PH_ATTACK;
               next_level = start_level;
            end
            CMD_NOTE_OFF: begin
               next_phase    = PH_RELEASE;
               next_progress = '0;
            end
            default: ;  // unused code: echo, no state change
         endcase
      end
   end

endmodule

// ===== sv/linear_adsr_envelope.sv =====
// ----------------------------------------------------------------------------
// Linear ADSR envelope - top level
// Q-format linear attack/decay/sustain/release stepper, one beat per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): valid/ready beats carrying a command (tick,
//    note on, note off) and the current level. Response channel (rsp_*):
//    one beat per request with the new level and the phase after the step.
//  - csr_* writes a control register by index; write only
//    while no request is in flight.
//  - An accepted request beat goes into the input register, then through
//    the step logic into the response register, which raises rsp_valid.
//  - Throughput is one beat per cycle while rsp_ready is high; phase and
//    release progress are updated as a beat moves from the input register
//    to the response register, so back-to-back beats see each other's state.
//  - When the receiver stalls, the response register holds and the input
//    register takes one more beat before req_ready drops.
//  - Reset (synchronous) empties both registers, sets the phase to idle,
//    clears release progress and loads the register defaults.
// ----------------------------------------------------------------------------
`include "linear_adsr_envelope_defines.svh"

module linear_adsr_envelope #(
   parameter int LEVEL_FRAC_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_cmd,
   input  logic [LEVEL_FRAC_BITS:0]             req_current_level,
   // response
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [LEVEL_FRAC_BITS:0]             rsp_level,
   output logic [2:0]                           rsp_phase,
   // control registers
   input  logic                                 csr_write_enable,
   input  logic [lae_pkg::REG_INDEX_BITS-1:0]   csr_index,
   input  logic [LEVEL_FRAC_BITS:0]             csr_write_data
);
   import lae_pkg::*;

   localparam int LW = LEVEL_FRAC_BITS + 1;
   localparam logic [LW-1:0] ONE_LVL = LW'(1) << LEVEL_FRAC_BITS;

   logic [LW-1:0]  attack_step;
   logic [LW-1:0]  decay_step;
   logic [LW-1:0]  release_step;
   logic [LW-1:0]  release_time_step;
   logic [LW-1:0]  sustain_level;
   logic [LW-1:0]  start_level;
   ctrl_flags_type flags;

   logic           s1_valid_ff;
   logic [1:0]     s1_cmd_ff;
   logic [LW-1:0]  s1_level_ff;
   logic           rsp_valid_ff;
   logic [LW-1:0]  rsp_level_ff;
   phase_type      rsp_phase_ff;
   phase_type      phase_ff;
   logic [LW-1:0]  progress_ff;

   logic [LW-1:0]  level_in;
   phase_type      phase_in;
   logic [LW-1:0]  progress_in;
   logic           out_free;
   logic           s1_fire;

   lae_csr #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_csr (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .attack_step       (attack_step),
      .decay_step        (decay_step),
      .release_step      (release_step),
      .release_time_step (release_time_step),
      .sustain_level     (sustain_level),
      .start_level       (start_level),
      .flags             (flags)
   );

   lae_step #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_step (
      .cmd               (s1_cmd_ff),
      .cur_level         (s1_level_ff),
      .phase             (phase_ff),
      .progress          (progress_ff),
      .attack_step       (attack_step),
      .decay_step        (decay_step),
      .release_step      (release_step),
      .release_time_step (release_time_step),
      .sustain_level     (sustain_level),
      .start_level       (start_level),
      .flags             (flags),
      .next_level        (level_in),
      .next_phase        (phase_in),
      .next_progress     (progress_in)
   );

   // handshake: response register free or draining this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_cmd_ff   <= req_cmd;
         s1_level_ff <= req_current_level;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_level_ff <= level_in;
         rsp_phase_ff <= phase_in;
      end
   end

   // envelope state, advanced once per beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         progress_ff <= '0;
      end else if (s1_fire) begin
         phase_ff    <= phase_in;
         progress_ff <= progress_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;
   assign rsp_phase = rsp_phase_ff;

   // checks
   `LAE_ASSERT_NOW(a_progress_below_one, clock, reset, 1'b1, progress_ff[LW-1] == 1'b0)
   `LAE_ASSERT_NEXT(a_bypass_full, clock, reset, s1_fire && flags.bypass, rsp_level == ONE_LVL)
   `LAE_ASSERT_NEXT(a_s1_held, clock, reset, s1_valid_ff && !s1_fire, s1_valid_ff)
   `LAE_ASSERT_NEXT(a_rsp_follows_state, clock, reset, s1_fire, rsp_valid && rsp_phase_ff == phase_ff)

endmodule

// ===== tb/lae_envelope_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linear ADSR envelope - scoreboard
// Watches the request, response and control ports of the envelope stepper,
// keeps its own copy of the control registers and envelope state, works out
// the level and phase for every accepted request beat and compares them with
// the response beats in order.
// ----------------------------------------------------------------------------
module lae_envelope_checker #(
   parameter int LEVEL_FRAC_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [1:0]                           req_cmd,
   input  logic [LEVEL_FRAC_BITS:0]             req_current_level,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [LEVEL_FRAC_BITS:0]             rsp_level,
   input  logic [2:0]                           rsp_phase,
   input  logic                                 csr_write_enable,
   input  logic [lae_pkg::REG_INDEX_BITS-1:0]   csr_index,
   input  logic [LEVEL_FRAC_BITS:0]             csr_write_data,
   output int                                   error_count,
   output int                                   outstanding
);
   import lae_pkg::*;

   localparam int     LW      = LEVEL_FRAC_BITS + 1;
   localparam longint UNITY   = longint'(1) << LEVEL_FRAC_BITS;
   // 0.001 rounded to the nearest level step
   localparam longint SNAP    = (UNITY + 500) / 1000;

   typedef struct packed {
      logic [LW-1:0] level;
      logic [2:0]    phase;
   } env_beat_type;

   // control register copy
   longint    atk_step;
   longint    dcy_step;
   longint    rel_step;
   longint    rel_time_step;
   longint    sus_level;
   longint    start_lvl;
   logic      dcy_off;
   logic      byp;

   // envelope state
   phase_type env_phase;
   longint    rel_progress;

   env_beat_type expected_beats[$];
   int           mismatches = 0;

   assign error_count = mismatches;

   // one step of the envelope; updates phase and release progress
   function automatic env_beat_type advance_envelope(cmd_type cmd, logic [LW-1:0] cur);
      longint       lvl;
      longint       diff;
      env_beat_type res;
      lvl = longint'(cur);
      if (byp) begin
         lvl = UNITY;
      end else if (cmd == CMD_TICK) begin
         case (env_phase)
            PH_ATTACK: begin
               lvl = lvl + atk_step;
               if (lvl >= UNITY) begin
                  lvl = UNITY;
                  env_phase = PH_DECAY;
               end
            end
            PH_DECAY: begin
               if (dcy_off) begin
                  env_phase = PH_SUSTAIN;
                  lvl = UNITY;
               end else if (lvl > sus_level) begin
                  diff = lvl - dcy_step;
                  if (diff <= sus_level + SNAP) begin
                     env_phase = PH_SUSTAIN;
                     lvl = sus_level;
                  end else begin
                     lvl = diff;
                  end
               end else begin
                  env_phase = PH_SUSTAIN;
                  lvl = sus_level;
               end
            end
            PH_RELEASE: begin
               rel_progress = rel_progress + rel_time_step;
               if (rel_progress >= UNITY) begin
                  rel_progress = 0;
                  env_phase = PH_IDLE;
                  lvl = 0;
               end else begin
                  diff = lvl - rel_step;
                  if (diff <= SNAP) begin
                     env_phase = PH_IDLE;
                     lvl = 0;
                  end else begin
                     lvl = diff;
                  end
               end
            end
            default: ;
         endcase
      end else if (cmd == CMD_NOTE_ON) begin
         env_phase = PH_ATTACK;
         lvl = start_lvl;
      end else if (cmd == CMD_NOTE_OFF) begin
         env_phase = PH_RELEASE;
         rel_progress = 0;
      end
      res.level = lvl[LW-1:0];
      res.phase = env_phase;
      return res;
   endfunction

   always @(posedge clock) begin
      env_beat_type exp_beat;
      if (reset) begin
         atk_step      = 349525;
         dcy_step      = 349525;
         rel_step      = 0;
         rel_time_step = 349525;
         sus_level     = 0;
         start_lvl     = 0;
         dcy_off       = 1'b0;
         byp           = 1'b0;
         env_phase     = PH_IDLE;
         rel_progress  = 0;
         expected_beats.delete();
         outstanding  <= 0;
      end else begin
         // register writes
         if (csr_write_enable) begin
            case (csr_index)
               REG_ATTACK_STEP:       atk_step      = longint'(csr_write_data);
               REG_DECAY_STEP:        dcy_step      = longint'(csr_write_data);
               REG_RELEASE_STEP:      rel_step      = longint'(csr_write_data);
               REG_RELEASE_TIME_STEP: rel_time_step = longint'(csr_write_data);
               REG_SUSTAIN_LEVEL:     sus_level     = longint'(csr_write_data);
               REG_START_LEVEL:       start_lvl     = longint'(csr_write_data);
               REG_DECAY_DISABLED:    dcy_off       = csr_write_data[0];
               REG_BYPASS:            byp           = csr_write_data[0];
               default: ;
            endcase
         end

         // request beat: predict
         if (req_valid && req_ready)
            expected_beats.push_back(advance_envelope(cmd_type'(req_cmd), req_current_level));

         // response beat: compare with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response beat: level %h phase %0d",
                        $time, rsp_level, rsp_phase);
            end else begin
               exp_beat = expected_beats.pop_front();
               if (rsp_level !== exp_beat.level) begin
                  mismatches++;
                  $display("%0t: level mismatch: expected %h actual %h",
                           $time, exp_beat.level, rsp_level);
               end
               if (rsp_phase !== exp_beat.phase) begin
                  mismatches++;
                  $display("%0t: phase mismatch: expected %0d actual %0d",
                           $time, exp_beat.phase, rsp_phase);
               end
            end
         end
         outstanding <= expected_beats.size();
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linear ADSR envelope - testbench top
// Drives note-on, note-off and tick beats into the envelope stepper under
// several register settings and idle patterns; the scoreboard beside the
// block checks every response beat.
// ----------------------------------------------------------------------------
module tb_top;
   import lae_pkg::*;

   localparam int FRAC_BITS   = 24;
   localparam int LW          = FRAC_BITS + 1;
   localparam int UNITY       = 1 << FRAC_BITS;
   localparam int SNAP        = (UNITY + 500) / 1000;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;

   typedef struct {
      logic [LW-1:0] attack_step;
      logic [LW-1:0] decay_step;
      logic [LW-1:0] rel_step;
      logic [LW-1:0] rel_time_step;
      logic [LW-1:0] sustain_level;
      logic [LW-1:0] start_level;
      logic          decay_off;
      logic          bypass_on;
   } env_settings_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [1:0]                req_cmd;
   logic [LW-1:0]             req_current_level;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [LW-1:0]             rsp_level;
   logic [2:0]                rsp_phase;
   logic                      csr_write_enable;
   logic [REG_INDEX_BITS-1:0] csr_index;
   logic [LW-1:0]             csr_write_data;

   int               error_count;
   int               outstanding;
   int               cycle_count   = 0;
   int               beats_sent    = 0;
   int               req_idle_pct  = 0;
   int               rsp_idle_pct  = 0;
   bit               start_hold    = 1'b0;
   bit               hold_done     = 1'b0;
   int               hold_left     = 0;
   env_settings_type active_settings;

   linear_adsr_envelope #(
      .LEVEL_FRAC_BITS (FRAC_BITS)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_current_level (req_current_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_level         (rsp_level),
      .rsp_phase         (rsp_phase),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   lae_envelope_checker #(
      .LEVEL_FRAC_BITS (FRAC_BITS)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_current_level (req_current_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_level         (rsp_level),
      .rsp_phase         (rsp_phase),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .error_count       (error_count),
      .outstanding       (outstanding)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // response side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (start_hold && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // one request beat; valid stays up into the next beat unless we idle
   task automatic send_beat(input cmd_type cmd, input logic [LW-1:0] lvl);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_current_level <= lvl;
      do @(posedge clock); while (!req_ready);
      if (cmd != CMD_UNUSED)
         beats_sent++;
   endtask

   // stop sending and let every response drain, plus pipeline slack
   task automatic quiesce();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [LW-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(input env_settings_type s);
      write_reg(REG_ATTACK_STEP,       s.attack_step);
      write_reg(REG_DECAY_STEP,        s.decay_step);
      write_reg(REG_RELEASE_STEP,      s.rel_step);
      write_reg(REG_RELEASE_TIME_STEP, s.rel_time_step);
      write_reg(REG_SUSTAIN_LEVEL,     s.sustain_level);
      write_reg(REG_START_LEVEL,       s.start_level);
      write_reg(REG_DECAY_DISABLED,    {{(LW-1){1'b0}}, s.decay_off});
      write_reg(REG_BYPASS,            {{(LW-1){1'b0}}, s.bypass_on});
      csr_write_enable <= 1'b0;
      active_settings = s;
   endtask

   function automatic env_settings_type random_settings();
      env_settings_type s;
      s.attack_step   = LW'($urandom_range(UNITY / 3, UNITY / 64));
      s.decay_step    = LW'($urandom_range(UNITY / 3, UNITY / 64));
      s.rel_step      = LW'($urandom_range(UNITY / 4, 0));
      s.rel_time_step = LW'($urandom_range(UNITY / 2, UNITY / 32));
      s.sustain_level = LW'($urandom_range(UNITY, 0));
      s.start_level   = LW'($urandom_range(UNITY, 0));
      s.decay_off     = ($urandom_range(3) == 0);
      s.bypass_on     = 1'b0;
      return s;
   endfunction

   // current level, biased toward the thresholds of the active settings
   function automatic logic [LW-1:0] pick_level();
      longint      v;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 30) begin
         v = $urandom_range(UNITY, 0);
      end else if (roll < 45) begin
         v = longint'(UNITY) - longint'($urandom_range(active_settings.attack_step, 0));
      end else if (roll < 65) begin
         v = longint'(active_settings.sustain_level)
             + longint'($urandom_range(active_settings.decay_step + 2 * SNAP, 0));
      end else if (roll < 80) begin
         v = $urandom_range(active_settings.rel_step + 2 * SNAP, 0);
      end else if (roll < 90) begin
         case ($urandom_range(5))
            0:       v = 0;
            1:       v = SNAP;
            2:       v = longint'(active_settings.sustain_level) + SNAP;
            3:       v = UNITY;
            4:       v = longint'(active_settings.rel_step) + SNAP;
            default: v = longint'(active_settings.sustain_level)
                         + longint'(active_settings.decay_step) + SNAP;
         endcase
      end else begin
         // anything the port can carry, above 1.0 included
         return LW'($urandom());
      end
      if (v > UNITY)
         v = UNITY;
      return v[LW-1:0];
   endfunction

   // note on, some ticks, usually a note off and release ticks
   task automatic play_note();
      int n;
      send_beat(CMD_NOTE_ON, pick_level());
      n = $urandom_range(16, 1);
      repeat (n) send_beat(CMD_TICK, pick_level());
      if ($urandom_range(3) != 0) begin
         send_beat(CMD_NOTE_OFF, pick_level());
         n = $urandom_range(24, 1);
         repeat (n) send_beat(CMD_TICK, pick_level());
      end
   endtask

   task automatic run_random(input int beats);
      int goal;
      goal = beats_sent + beats;
      while (beats_sent < goal) begin
         if ($urandom_range(99) < 15)
            send_beat(cmd_type'($urandom_range(3)), pick_level());
         else
            play_note();
      end
   endtask

   initial begin
      env_settings_type s;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_cmd          = CMD_TICK;
      req_current_level = '0;
      csr_write_enable = 1'b0;
      csr_index        = REG_ATTACK_STEP;
      csr_write_data   = '0;

      // register defaults as seen after reset
      active_settings.attack_step   = 349525;
      active_settings.decay_step    = 349525;
      active_settings.rel_step      = 0;
      active_settings.rel_time_step = 349525;
      active_settings.sustain_level = 0;
      active_settings.start_level   = 0;
      active_settings.decay_off     = 1'b0;
      active_settings.bypass_on     = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 19;
      rsp_idle_pct = 72;

      // directed, reset settings: idle echo, over-range level, unused command
      send_beat(CMD_TICK,     '0);
      send_beat(CMD_TICK,     25'h1FFFFFF);
      send_beat(CMD_UNUSED,   25'h0AAAAAA);
      // attack ramp, clamp at 1.0, decay, snap to sustain, sustain echo
      send_beat(CMD_NOTE_ON,  25'h1555555);
      send_beat(CMD_TICK,     '0);
      send_beat(CMD_TICK,     LW'(UNITY - 1));
      send_beat(CMD_TICK,     LW'(UNITY));
      send_beat(CMD_TICK,     LW'(349525 + SNAP));
      send_beat(CMD_TICK,     12345);
      // attack from above 1.0, decay starting at or below sustain
      send_beat(CMD_NOTE_ON,  '0);
      send_beat(CMD_TICK,     25'h1FFFFFF);
      send_beat(CMD_TICK,     '0);
      // release with zero release step: hold, end at the snap edge
      send_beat(CMD_NOTE_OFF, 25'h0AAAAAA);
      send_beat(CMD_TICK,     LW'(UNITY));
      send_beat(CMD_TICK,     LW'(SNAP));
      send_beat(CMD_NOTE_OFF, LW'(UNITY));
      send_beat(CMD_TICK,     LW'(SNAP + 1));
      quiesce();

      // directed: full attack step, decay disabled, release ends by time
      s = active_settings;
      s.attack_step   = LW'(UNITY);
      s.decay_step    = LW'(UNITY / 4);
      s.rel_step      = LW'(UNITY / 8);
      s.rel_time_step = LW'(UNITY / 2);
      s.sustain_level = LW'(UNITY / 4);
      s.start_level   = LW'(UNITY);
      s.decay_off     = 1'b1;
      apply_settings(s);
      send_beat(CMD_NOTE_ON,  '0);
      send_beat(CMD_TICK,     LW'(UNITY));
      send_beat(CMD_TICK,     5);
      send_beat(CMD_NOTE_OFF, LW'(UNITY));
      send_beat(CMD_TICK,     LW'(UNITY));
      send_beat(CMD_TICK,     LW'(UNITY));
      quiesce();

      // directed: bypass forces 1.0 and holds the phase
      s.bypass_on = 1'b1;
      apply_settings(s);
      send_beat(CMD_NOTE_ON,  7);
      send_beat(CMD_TICK,     '0);
      send_beat(CMD_NOTE_OFF, 3);
      quiesce();

      // random: moderate steps
      apply_settings(random_settings());
      run_random(50);
      quiesce();

      // random: every step and level at 1.0, decay disabled
      s.attack_step   = LW'(UNITY);
      s.decay_step    = LW'(UNITY);
      s.rel_step      = LW'(UNITY);
      s.rel_time_step = LW'(UNITY);
      s.sustain_level = LW'(UNITY);
      s.start_level   = LW'(UNITY);
      s.decay_off     = 1'b1;
      s.bypass_on     = 1'b0;
      apply_settings(s);
      run_random(50);
      quiesce();

      // swap idle pattern: sender sparse, receiver mostly ready
      req_idle_pct = 72;
      rsp_idle_pct = 19;

      // random: all zero, release only ends on level
      s.attack_step   = 0;
      s.decay_step    = 0;
      s.rel_step      = 0;
      s.rel_time_step = 0;
      s.sustain_level = 0;
      s.start_level   = 0;
      s.decay_off     = 1'b0;
      apply_settings(s);
      run_random(50);
      quiesce();

      // random under bypass
      s = random_settings();
      s.bypass_on = 1'b1;
      apply_settings(s);
      run_random(20);
      quiesce();

      // no idling; receiver holds off while requests keep coming
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      apply_settings(random_settings());
      start_hold = 1'b1;
      run_random(50);
      quiesce();

      apply_settings(random_settings());
      run_random(50);
      quiesce();

      s = random_settings();
      s.decay_off = 1'b0;
      apply_settings(s);
      run_random(40);
      quiesce();

      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== linear_adsr_envelope.f =====
+incdir+sv
sv/lae_pkg.sv
sv/lae_csr.sv
sv/lae_step.sv
sv/linear_adsr_envelope.sv
tb/lae_envelope_checker.sv
tb/tb_top.sv
